>>> hdl/uera_pkg.sv
// shared types, constants and microcode encodings for the echo range averager
// no dependencies; imported by every module under hdl
package uera_pkg;

	localparam int MAX_SAMPLES = 5;

	localparam int SAMP_W = 3;
	localparam int TRIG_W = 8;
	localparam int GAP_W  = 16;
	localparam int PC_W   = 16;
	localparam int ECNT_W = 16;
	localparam int SUM_W  = 13;
	localparam int DIST_W = 11;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 16;

	localparam int DIST_MAX   = 1115;
	localparam int SUM_MAX    = MAX_SAMPLES * DIST_MAX;

	// ticks to cm: floor(n * 100 / 5877) taken as (n * CM_RECIP) >> CM_SHIFT
	localparam int RECIP_W  = 24;
	localparam int CM_SHIFT = 29;
	localparam logic [RECIP_W-1:0] CM_RECIP = 24'd9135119;

	// shift-subtract divider
	localparam int DVD_W  = 23;
	localparam int REM_W  = 13;
	localparam int DCNT_W = $clog2(DVD_W + 1);

	localparam logic [SAMP_W-1:0] SAMP_RST = 3'd1;
	localparam logic [TRIG_W-1:0] TRIG_RST = 8'd20;
	localparam logic [GAP_W-1:0]  GAP_RST  = 16'd50000;

	typedef enum logic [CIDX_W-1:0] {
		CFG_SAMPLE_COUNT  = 2'd0,
		CFG_TRIGGER_TICKS = 2'd1,
		CFG_GAP_TICKS     = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TRIG = 3'd1,
		PH_RISE = 3'd2,
		PH_MEAS = 3'd3,
		PH_GAP  = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		OP_NOP        = 4'd0,
		OP_FETCH      = 4'd1,
		OP_START_SEQ  = 4'd2,
		OP_INC_PC     = 4'd3,
		OP_SET_RISE   = 4'd4,
		OP_ECHO_FIRST = 4'd5,
		OP_ECHO_INC   = 4'd6,
		OP_CONV_LOAD  = 4'd7,
		OP_DIV_STEP   = 4'd8,
		OP_ADD_SAMPLE = 4'd9,
		OP_AVG_LOAD   = 4'd10,
		OP_FINISH     = 4'd11,
		OP_BEGIN_TRIG = 4'd12,
		OP_EMIT       = 4'd13
	} op_t;

	typedef enum logic [3:0] {
		C_NONE         = 4'd0,
		C_NO_REQ       = 4'd1,
		C_PH_IDLE      = 4'd2,
		C_PH_TRIG      = 4'd3,
		C_PH_RISE      = 4'd4,
		C_PH_MEAS      = 4'd5,
		C_NO_START     = 4'd6,
		C_TRIG_DONE    = 4'd7,
		C_NO_ECHO      = 4'd8,
		C_DIV_BUSY     = 4'd9,
		C_GAP_RUN      = 4'd10,
		C_MORE_SAMPLES = 4'd11,
		C_OUT_BUSY     = 4'd12
	} cond_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// microprogram addresses
	localparam upc_t A_FETCH      = 5'd0;
	localparam upc_t A_D_IDLE     = 5'd1;
	localparam upc_t A_D_TRIG     = 5'd2;
	localparam upc_t A_D_RISE     = 5'd3;
	localparam upc_t A_D_MEAS     = 5'd4;
	localparam upc_t A_IDLE_CHK   = 5'd5;
	localparam upc_t A_START      = 5'd6;
	localparam upc_t A_TRIG_CHK   = 5'd7;
	localparam upc_t A_TRIG_INC   = 5'd8;
	localparam upc_t A_TRIG_END   = 5'd9;
	localparam upc_t A_RISE_CHK   = 5'd10;
	localparam upc_t A_RISE_HIT   = 5'd11;
	localparam upc_t A_MEAS_CHK   = 5'd12;
	localparam upc_t A_MEAS_INC   = 5'd13;
	localparam upc_t A_CONV_LOAD  = 5'd14;
	localparam upc_t A_ADD_SAMPLE = 5'd15;
	localparam upc_t A_GAP_CHK    = 5'd16;
	localparam upc_t A_GAP_INC    = 5'd17;
	localparam upc_t A_MORE_CHK   = 5'd18;
	localparam upc_t A_NEXT_TRIG  = 5'd19;
	localparam upc_t A_AVG_LOAD   = 5'd20;
	localparam upc_t A_AVG_STEP   = 5'd21;
	localparam upc_t A_FINISH     = 5'd22;
	localparam upc_t A_EMIT       = 5'd23;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  br;
		upc_t  nx;
	} ucw_t;

	typedef struct packed {
		logic start;
		logic echo;
		logic ph_idle;
		logic ph_trig;
		logic ph_rise;
		logic ph_meas;
		logic trig_done;
		logic gap_run;
		logic more_samples;
		logic div_busy;
	} flags_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_cm;
		logic              done_res;
		logic              busy_res;
		logic              trigger;
	} res_t;

endpackage

>>> hdl/uera_ucode_rom.sv
// microprogram store: one control word per step address
// depends on uera_pkg
module uera_ucode_rom (
	input  uera_pkg::upc_t addr,
	output uera_pkg::ucw_t cw
);
	import uera_pkg::*;

	function automatic ucw_t mk(op_t op, cond_t cond, upc_t br, upc_t nx);
		ucw_t w;
		w.op   = op;
		w.cond = cond;
		w.br   = br;
		w.nx   = nx;
		return w;
	endfunction

	always_comb begin
		unique case (addr)
			A_FETCH:      cw = mk(OP_FETCH,      C_NO_REQ,       A_FETCH,     A_D_IDLE);
			A_D_IDLE:     cw = mk(OP_NOP,        C_PH_IDLE,      A_IDLE_CHK,  A_D_TRIG);
			A_D_TRIG:     cw = mk(OP_NOP,        C_PH_TRIG,      A_TRIG_CHK,  A_D_RISE);
			A_D_RISE:     cw = mk(OP_NOP,        C_PH_RISE,      A_RISE_CHK,  A_D_MEAS);
			A_D_MEAS:     cw = mk(OP_NOP,        C_PH_MEAS,      A_MEAS_CHK,  A_GAP_CHK);
			A_IDLE_CHK:   cw = mk(OP_NOP,        C_NO_START,     A_EMIT,      A_START);
			A_START:      cw = mk(OP_START_SEQ,  C_NONE,         A_EMIT,      A_EMIT);
			A_TRIG_CHK:   cw = mk(OP_NOP,        C_TRIG_DONE,    A_TRIG_END,  A_TRIG_INC);
			A_TRIG_INC:   cw = mk(OP_INC_PC,     C_NONE,         A_EMIT,      A_EMIT);
			A_TRIG_END:   cw = mk(OP_SET_RISE,   C_NONE,         A_EMIT,      A_EMIT);
			A_RISE_CHK:   cw = mk(OP_NOP,        C_NO_ECHO,      A_EMIT,      A_RISE_HIT);
			A_RISE_HIT:   cw = mk(OP_ECHO_FIRST, C_NONE,         A_EMIT,      A_EMIT);
			A_MEAS_CHK:   cw = mk(OP_NOP,        C_NO_ECHO,      A_CONV_LOAD, A_MEAS_INC);
			A_MEAS_INC:   cw = mk(OP_ECHO_INC,   C_NONE,         A_EMIT,      A_EMIT);
			A_CONV_LOAD:  cw = mk(OP_CONV_LOAD,  C_NONE,         A_ADD_SAMPLE, A_ADD_SAMPLE);
			A_ADD_SAMPLE: cw = mk(OP_ADD_SAMPLE, C_NONE,         A_EMIT,      A_EMIT);
			A_GAP_CHK:    cw = mk(OP_NOP,        C_GAP_RUN,      A_GAP_INC,   A_MORE_CHK);
			A_GAP_INC:    cw = mk(OP_INC_PC,     C_NONE,         A_EMIT,      A_EMIT);
			A_MORE_CHK:   cw = mk(OP_NOP,        C_MORE_SAMPLES, A_NEXT_TRIG, A_AVG_LOAD);
			A_NEXT_TRIG:  cw = mk(OP_BEGIN_TRIG, C_NONE,         A_EMIT,      A_EMIT);
			A_AVG_LOAD:   cw = mk(OP_AVG_LOAD,   C_NONE,         A_AVG_STEP,  A_AVG_STEP);
			A_AVG_STEP:   cw = mk(OP_DIV_STEP,   C_DIV_BUSY,     A_AVG_STEP,  A_FINISH);
			A_FINISH:     cw = mk(OP_FINISH,     C_NONE,         A_EMIT,      A_EMIT);
			A_EMIT:       cw = mk(OP_EMIT,       C_OUT_BUSY,     A_EMIT,      A_FETCH);
			default:      cw = mk(OP_NOP,        C_NONE,         A_FETCH,     A_FETCH);
		endcase
	end

endmodule

>>> hdl/uera_sequencer.sv
// step counter with condition select and two-way branch
// depends on uera_pkg; fed by uera_ucode_rom and uera_datapath flags
module uera_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  uera_pkg::ucw_t  cw,
	input  uera_pkg::flags_t flags,
	input  logic            req_valid,
	input  logic            out_free,
	output uera_pkg::upc_t  upc
);
	import uera_pkg::*;

	upc_t upc_q;
	logic hit;

	always_comb begin
		unique case (cw.cond)
			C_NONE:         hit = 1'b0;
			C_NO_REQ:       hit = !req_valid;
			C_PH_IDLE:      hit = flags.ph_idle;
			C_PH_TRIG:      hit = flags.ph_trig;
			C_PH_RISE:      hit = flags.ph_rise;
			C_PH_MEAS:      hit = flags.ph_meas;
			C_NO_START:     hit = !flags.start;
			C_TRIG_DONE:    hit = flags.trig_done;
			C_NO_ECHO:      hit = !flags.echo;
			C_DIV_BUSY:     hit = flags.div_busy;
			C_GAP_RUN:      hit = flags.gap_run;
			C_MORE_SAMPLES: hit = flags.more_samples;
			C_OUT_BUSY:     hit = !out_free;
			default:        hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_FETCH;
		end else begin
			upc_q <= hit ? cw.br : cw.nx;
		end
	end

	assign upc = upc_q;

	a_upc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= A_EMIT)
		else $error("step counter left the program");

endmodule

>>> hdl/uera_datapath.sv
// measurement state, configuration registers, cm conversion and averaging divider
// depends on uera_pkg; driven by the control word from uera_ucode_rom
module uera_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uera_pkg::op_t                 op,
	input  logic                          req_valid,
	input  logic                          start_in,
	input  logic                          echo_in,
	input  logic                          cfg_we,
	input  logic [uera_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [uera_pkg::CDAT_W-1:0]   cfg_dat,
	output uera_pkg::flags_t              flags,
	output uera_pkg::res_t                res
);
	import uera_pkg::*;

	logic [SAMP_W-1:0] samp_q;
	logic [TRIG_W-1:0] trig_q;
	logic [GAP_W-1:0]  gap_q;

	phase_t            phase_q;
	logic [PC_W-1:0]   pc_q;
	logic [ECNT_W-1:0] echo_cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SAMP_W-1:0] taken_q;
	logic [DIST_W-1:0] dist_q;
	logic              done_q;
	logic              start_q;
	logic              echo_q;

	logic [REM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [REM_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [SAMP_W-1:0] samp_wr;
	logic [TRIG_W-1:0] trig_wr;
	logic [ECNT_W+RECIP_W-1:0] conv_prod;
	logic [REM_W:0]    div_t;
	logic [REM_W:0]    div_sub;
	logic              div_ge;
	logic [SUM_W-1:0]  sum_add;

	// config write clamping
	always_comb begin
		samp_wr = cfg_dat[SAMP_W-1:0];
		if (samp_wr == '0) begin
			samp_wr = SAMP_W'(1);
		end else if (samp_wr > SAMP_W'(MAX_SAMPLES)) begin
			samp_wr = SAMP_W'(MAX_SAMPLES);
		end
		trig_wr = cfg_dat[TRIG_W-1:0];
		if (trig_wr == '0) begin
			trig_wr = TRIG_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_q <= SAMP_RST;
			trig_q <= TRIG_RST;
			gap_q  <= GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SAMPLE_COUNT:  samp_q <= samp_wr;
				CFG_TRIGGER_TICKS: trig_q <= trig_wr;
				CFG_GAP_TICKS:     gap_q  <= cfg_dat[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// reciprocal multiply, exact for every 16-bit tick count
	assign conv_prod = {{RECIP_W{1'b0}}, echo_cnt_q} * {{ECNT_W{1'b0}}, CM_RECIP};

	assign div_t   = {rem_q, quo_q[DVD_W-1]};
	assign div_ge  = div_t >= {1'b0, dvs_q};
	assign div_sub = div_t - {1'b0, dvs_q};
	assign sum_add = sum_q + {{(SUM_W-DIST_W){1'b0}}, quo_q[DIST_W-1:0]};

	always_ff @(posedge clk) begin
		unique case (op)
			OP_CONV_LOAD: begin
				quo_q  <= {{(DVD_W-DIST_W){1'b0}}, conv_prod[CM_SHIFT +: DIST_W]};
			end
			OP_AVG_LOAD: begin
				rem_q  <= '0;
				quo_q  <= {sum_q, {(DVD_W-SUM_W){1'b0}}};
				dvs_q  <= {{(REM_W-SAMP_W){1'b0}}, samp_q};
				dcnt_q <= DCNT_W'(SUM_W);
			end
			OP_DIV_STEP: begin
				rem_q  <= div_ge ? div_sub[REM_W-1:0] : div_t[REM_W-1:0];
				quo_q  <= {quo_q[DVD_W-2:0], div_ge};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pc_q       <= '0;
			echo_cnt_q <= '0;
			sum_q      <= '0;
			taken_q    <= '0;
			dist_q     <= '0;
			done_q     <= 1'b0;
			start_q    <= 1'b0;
			echo_q     <= 1'b0;
		end else begin
			unique case (op)
				OP_FETCH: begin
					if (req_valid) begin
						start_q <= start_in;
						echo_q  <= echo_in;
						done_q  <= 1'b0;
					end
				end
				OP_START_SEQ: begin
					sum_q   <= '0;
					taken_q <= '0;
					phase_q <= PH_TRIG;
					pc_q    <= PC_W'(1);
				end
				OP_INC_PC:   pc_q <= pc_q + PC_W'(1);
				OP_SET_RISE: phase_q <= PH_RISE;
				OP_ECHO_FIRST: begin
					echo_cnt_q <= ECNT_W'(1);
					phase_q    <= PH_MEAS;
				end
				OP_ECHO_INC: begin
					if (echo_cnt_q != '1) begin
						echo_cnt_q <= echo_cnt_q + ECNT_W'(1);
					end
				end
				OP_ADD_SAMPLE: begin
					sum_q   <= sum_add;
					taken_q <= taken_q + SAMP_W'(1);
					phase_q <= PH_GAP;
					pc_q    <= '0;
				end
				OP_FINISH: begin
					dist_q  <= quo_q[DIST_W-1:0];
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
					pc_q    <= '0;
				end
				OP_BEGIN_TRIG: begin
					phase_q <= PH_TRIG;
					pc_q    <= PC_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		flags.start        = start_q;
		flags.echo         = echo_q;
		flags.ph_idle      = phase_q == PH_IDLE;
		flags.ph_trig      = phase_q == PH_TRIG;
		flags.ph_rise      = phase_q == PH_RISE;
		flags.ph_meas      = phase_q == PH_MEAS;
		flags.trig_done    = pc_q >= {{(PC_W-TRIG_W){1'b0}}, trig_q};
		flags.gap_run      = pc_q < gap_q;
		flags.more_samples = taken_q < samp_q;
		flags.div_busy     = dcnt_q != DCNT_W'(1);
	end

	always_comb begin
		res.trigger     = phase_q == PH_TRIG;
		res.busy_res    = phase_q != PH_IDLE;
		res.done_res    = done_q;
		res.distance_cm = dist_q;
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_DIV_STEP |-> dvs_q != '0)
		else $error("divider stepping with a zero divisor");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("distance sum beyond the largest possible total");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_FINISH |=> done_q && phase_q == PH_IDLE)
		else $error("finish step did not flag a new distance");

endmodule

>>> hdl/ultrasonic_echo_range_averager_top.sv
// top level of the ultrasonic echo range averager: stream ports and output register
// depends on uera_pkg, uera_ucode_rom, uera_sequencer, uera_datapath

// One input request is one 1 us tick carrying the start request and the sampled echo
// level; every request yields exactly one result (trigger level, busy, done pulse and the
// latest averaged distance in cm). Requests are handled one at a time by a microcoded
// sequencer, and a request can also be held by a stall on the output side.
// Most ticks are set by the phase dispatch chain of the program; the tick on which echo
// falls adds a single reciprocal multiply for the cm conversion. The long one is the
// last pause tick of a run (a 13-step division of the sum by sample_count). A finished
// result sits in an output register, so the next request is taken while it waits.
// Configuration writes are accepted at any cycle and should only be made while
// busy_res is low.
module ultrasonic_echo_range_averager_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] start_req, [1] echo, [7:2] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
	                                    // [13:3] distance_cm, [15:14] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [uera_pkg::CIDX_W-1:0] cfg_index,
	input  logic [uera_pkg::CDAT_W-1:0] cfg_data
);
	import uera_pkg::*;

	upc_t   upc;
	ucw_t   cw;
	flags_t flags;
	res_t   res;
	res_t   m_data_q;
	logic   m_valid_q;
	logic   out_free;
	logic   emit_fire;

	assign out_free  = !m_valid_q || m_axis_tready;
	assign emit_fire = (cw.op == OP_EMIT) && out_free;

	assign s_axis_tready = cw.op == OP_FETCH;
	assign cfg_ready     = 1'b1;

	uera_ucode_rom u_rom (
		.addr (upc),
		.cw   (cw)
	);

	uera_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.flags     (flags),
		.req_valid (s_axis_tvalid),
		.out_free  (out_free),
		.upc       (upc)
	);

	uera_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (cw.op),
		.req_valid (s_axis_tvalid),
		.start_in  (s_axis_tdata[0]),
		.echo_in   (s_axis_tdata[1]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_dat   (cfg_data),
		.flags     (flags),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_data_q};

endmodule
